// File: src/rtm_pkg.sv
// ----------------------------------------------------------------------------
// rtm_pkg: shared types and constants for the rescaled tent-map generator
// Controller/datapath command and status groups, state codes, register map
// and reset values.
// ----------------------------------------------------------------------------
package rtm_pkg;

  // configuration port geometry (64-bit registers at 8-byte spacing)
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  // register index codes, taken from address bit 3
  localparam logic REG_SEED  = 1'b0;
  localparam logic REG_SLOPE = 1'b1;

  // register reset values
  localparam logic [63:0] SEED_RESET  = 64'd1431655765;
  localparam logic [31:0] SLOPE_RESET = 32'd510027366;

  // bits of the state consumed per multiplier pass
  localparam int MUL_CHUNK = 16;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } rtm_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic mul_step;
    logic eval;
    logic div_step;
    logic commit;
  } rtm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic need_div;
  } rtm_status_t;

endpackage

// File: src/rescaled_tent_map_generator_top.sv
// ----------------------------------------------------------------------------
// rescaled_tent_map_generator_top: chaotic tent-map sequence generator
// Streams one sample per restart/continue request and advances the orbit.
// ----------------------------------------------------------------------------
// From input transaction to result, an item is loaded, takes the multiplier
// passes and the evaluation, then, when a division is needed, the restoring
// divider, one quotient bit a cycle, before the commit to the output register.
// One item at a time: a new transaction is taken once the sequencer is back in
// idle after the previous result is stored in the output register.
// Reset (synchronous, rst_n low): default seed and slope, clamped orbit, no result.
module rescaled_tent_map_generator_top #(
  parameter int STATE_FRAC_BITS = 32,
  parameter int SLOPE_INT_BITS  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] restart, [7:1] zero
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] sample
  output logic        out_tuser,   // [0] fault
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [rtm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rtm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [rtm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [STATE_FRAC_BITS:0] seed;
  logic [31:0]              slope;
  rtm_pkg::rtm_cmd_t        cmd;
  rtm_pkg::rtm_status_t     status;

  // configuration registers
  rtm_cfg_regs #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .seed        (seed),
    .slope       (slope)
  );

  // sequencer
  rtm_ctrl #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath
  rtm_dpath #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS),
    .SLOPE_INT_BITS  (SLOPE_INT_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_restart (in_tdata[0]),
    .seed       (seed),
    .slope      (slope),
    .out_sample (out_tdata),
    .out_fault  (out_tuser)
  );

endmodule

// File: src/rtm_cfg_regs.sv
// ----------------------------------------------------------------------------
// rtm_cfg_regs: configuration register file
// Holds the seed and slope registers behind an APB-style port.
// ----------------------------------------------------------------------------
module rtm_cfg_regs #(
  parameter int STATE_FRAC_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rtm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [rtm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [rtm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output logic [STATE_FRAC_BITS:0]        seed,
  output logic [31:0]                     slope
);

  localparam int XW = STATE_FRAC_BITS + 1;

  logic [XW-1:0] seed_r, seed_nxt;
  logic [31:0]   slope_r, slope_nxt;
  logic          wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register write decode
  always_comb begin
    seed_nxt  = seed_r;
    slope_nxt = slope_r;
    if (wr_en) begin
      case (cfg_paddr[3])
        rtm_pkg::REG_SEED:  seed_nxt  = cfg_pwdata[XW-1:0];
        rtm_pkg::REG_SLOPE: slope_nxt = cfg_pwdata[31:0];
        default: begin
          seed_nxt  = seed_r;
          slope_nxt = slope_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= rtm_pkg::SEED_RESET[XW-1:0];
      slope_r <= rtm_pkg::SLOPE_RESET;
    end else begin
      seed_r  <= seed_nxt;
      slope_r <= slope_nxt;
    end
  end

  // read mux
  always_comb begin
    case (cfg_paddr[3])
      rtm_pkg::REG_SEED:  cfg_prdata = rtm_pkg::CFG_DATA_W'(seed_r);
      rtm_pkg::REG_SLOPE: cfg_prdata = rtm_pkg::CFG_DATA_W'(slope_r);
      default:            cfg_prdata = '0;
    endcase
  end

  assign seed  = seed_r;
  assign slope = slope_r;

endmodule

// File: src/rtm_ctrl.sv
// ----------------------------------------------------------------------------
// rtm_ctrl: step sequencer
// One-hot state machine that walks an item through multiply, evaluate and
// divide phases and owns the input ready and output valid flags.
// ----------------------------------------------------------------------------
module rtm_ctrl #(
  parameter int STATE_FRAC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  rtm_pkg::rtm_status_t status,
  output rtm_pkg::rtm_cmd_t    cmd
);

  localparam int MUL_STEPS = (STATE_FRAC_BITS + rtm_pkg::MUL_CHUNK - 1) / rtm_pkg::MUL_CHUNK;
  localparam int DIV_STEPS = STATE_FRAC_BITS + 2;
  localparam int CW        = $clog2(DIV_STEPS);

  rtm_pkg::rtm_state_t state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == rtm_pkg::ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      rtm_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CW'(MUL_STEPS - 1);
          state_nxt = rtm_pkg::ST_MUL;
        end
      end
      rtm_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = rtm_pkg::ST_EVAL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      rtm_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.need_div) begin
          cnt_nxt   = CW'(DIV_STEPS - 1);
          state_nxt = rtm_pkg::ST_DIV;
        end else begin
          state_nxt = rtm_pkg::ST_DONE;
        end
      end
      rtm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = rtm_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      rtm_pkg::ST_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = rtm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rtm_pkg::ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtm_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: src/rtm_dpath.sv
// ----------------------------------------------------------------------------
// rtm_dpath: tent-map datapath
// Orbit state, chunked slope multiplier, fold and band evaluation, restoring
// divider and the output payload registers.
// ----------------------------------------------------------------------------
module rtm_dpath #(
  parameter int STATE_FRAC_BITS = 32,
  parameter int SLOPE_INT_BITS  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rtm_pkg::rtm_cmd_t    cmd,
  output rtm_pkg::rtm_status_t status,
  input  logic                 in_restart,
  input  logic [STATE_FRAC_BITS:0] seed,
  input  logic [31:0]          slope,
  output logic [31:0]          out_sample,
  output logic                 out_fault
);

  localparam int F     = STATE_FRAC_BITS;
  localparam int SF    = 32 - SLOPE_INT_BITS;
  localparam int XW    = F + 1;
  localparam int CH    = rtm_pkg::MUL_CHUNK;
  localparam int MCH   = (F + CH - 1) / CH;
  localparam int TW    = CH * MCH;
  localparam int PW    = 32 + TW;
  localparam int NW    = F + SF + 1;
  localparam int QW    = F + 2;
  localparam int RW    = SF + 1;

  localparam logic [XW-1:0] ONE      = XW'(1) << F;
  localparam logic [XW-1:0] HALF     = XW'(1) << (F - 1);
  localparam logic [PW-1:0] ONE_PW   = PW'(1) << F;
  localparam logic [QW-1:0] ONE_QW   = QW'(1) << F;
  localparam logic [31:0]   TWO_M    = 32'(1) << (SF + 1);
  localparam logic [31:0]   R_MASK   = TWO_M - 32'd1;
  localparam logic [XW-1:0] SEED_RST = rtm_pkg::SEED_RESET[XW-1:0];
  localparam logic [XW-1:0] X_RST    = (SEED_RST > ONE) ? ONE : SEED_RST;

  logic [XW-1:0] x_r, x_nxt;
  logic [TW-1:0] t_r;
  logic [PW-1:0] acc_r;
  logic [31:0]   sample_r;
  logic [XW-1:0] xn_r;
  logic          flt_r;
  logic          div_r;
  logic [RW-1:0] rem_r;
  logic [QW-1:0] dq_r;
  logic [31:0]   out_sample_r;
  logic          out_fault_r;

  logic [XW-1:0] x_ld, seed_cl, t_ld;
  logic [31:0]   smp_ld, smp_shift;
  logic [CH+31:0] pp;
  logic [PW-1:0] pv, lhs;
  logic [XW-1:0] x_fold;
  logic [F-1:0]  q;
  logic [RW-1:0] r;
  logic [31:0]   m_top;
  logic          m_le2, in_band, n_sat;
  logic [NW-1:0] n_full;
  logic [NW-QW-1:0] n_hi;
  logic [RW:0]   trial;
  logic          ge;
  logic [XW-1:0] x_div;

  // state at item start, with optional reload from seed
  assign seed_cl = (seed > ONE) ? ONE : seed;
  assign x_ld    = in_restart ? seed_cl : x_r;
  assign t_ld    = (x_ld < HALF) ? x_ld : (ONE - x_ld);

  // state scaled to 32 bits
  generate
    if (F >= 32) begin : g_smp_down
      assign smp_shift = x_ld[F-1 -: 32];
    end else begin : g_smp_up
      assign smp_shift = {x_ld[F-1:0], {(32 - F){1'b0}}};
    end
  endgenerate
  assign smp_ld = (x_ld >= ONE) ? 32'hFFFF_FFFF : smp_shift;

  // one partial product per pass, most significant chunk first
  assign pp = slope * t_r[TW-1 -: CH];

  // fold and band evaluation on the full product
  always_comb begin
    pv      = acc_r >> SF;
    x_fold  = (pv > ONE_PW) ? ONE : pv[XW-1:0];
    q       = pv[F-1:0];
    r       = slope[RW-1:0];
    m_top   = slope & ~R_MASK;
    lhs     = PW'(m_top) << (F - 1);
    in_band = (lhs <= acc_r);
    m_le2   = (slope <= TWO_M);
    n_full  = {q, {(SF + 1){1'b0}}};
    n_hi    = n_full[NW-1:QW];
    n_sat   = (RW'(n_hi) >= r);
    status.need_div = !m_le2 && in_band && (r != '0) && !n_sat;
  end

  // restoring divider step
  assign trial = {rem_r, dq_r[QW-1]};
  assign ge    = (trial >= {1'b0, r});
  assign x_div = (dq_r > ONE_QW) ? ONE : dq_r[XW-1:0];

  // orbit state
  always_comb begin
    x_nxt = x_r;
    if (cmd.load) begin
      x_nxt = x_ld;
    end else if (cmd.commit) begin
      x_nxt = div_r ? x_div : xn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= X_RST;
    end else begin
      x_r <= x_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r      <= TW'(t_ld);
      acc_r    <= '0;
      sample_r <= smp_ld;
    end
    if (cmd.mul_step) begin
      t_r   <= t_r << CH;
      acc_r <= (acc_r << CH) + PW'(pp);
    end
    if (cmd.eval) begin
      div_r <= 1'b0;
      flt_r <= 1'b0;
      if (m_le2) begin
        xn_r <= x_fold;
      end else if (!in_band) begin
        xn_r <= {1'b0, q};
      end else if (r == '0) begin
        xn_r  <= '0;
        flt_r <= 1'b1;
      end else if (n_sat) begin
        xn_r <= ONE;
      end else begin
        div_r <= 1'b1;
        rem_r <= RW'(n_hi);
        dq_r  <= n_full[QW-1:0];
      end
    end
    if (cmd.div_step) begin
      rem_r <= ge ? RW'(trial - {1'b0, r}) : trial[RW-1:0];
      dq_r  <= {dq_r[QW-2:0], ge};
    end
    if (cmd.commit) begin
      out_sample_r <= sample_r;
      out_fault_r  <= flt_r;
    end
  end

  assign out_sample = out_sample_r;
  assign out_fault  = out_fault_r;

endmodule

// File: tb/rescaled_tent_map_generator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rescaled_tent_map_generator_top_test: self-checking bench for the tent map
// Walks the seed and slope registers through edge values and random
// settings, streams restart/continue requests with random gaps and output
// stalls, and compares every sample and fault flag against a bit-exact
// fixed-point orbit predictor kept inside the bench.
// ----------------------------------------------------------------------------
module rescaled_tent_map_generator_top_test;

  // fixed-point geometry: state Q1.32, slope Q4.28
  localparam logic [63:0] UNIT      = 64'h1_0000_0000;
  localparam logic [63:0] HALF      = 64'h0_8000_0000;
  localparam logic [31:0] SLOPE_TWO = 32'h2000_0000;
  localparam logic [63:0] FOLD_MASK = 64'h1FFF_FFFF;
  localparam int          QUO_STEPS = 29;
  localparam int          LATENCY   = 45;
  localparam int          LIMIT     = 600000;
  localparam int          RAND_ITEMS = 1750;

  typedef struct packed {
    logic [31:0] sample;
    logic        fault;
  } tent_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;    // [0] restart, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] sample
  logic        out_tuser;          // [0] fault
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [rtm_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [rtm_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [rtm_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  // predictor copy of registers and orbit
  logic [32:0] seed_reg;
  logic [31:0] slope_reg;
  logic [32:0] orbit_x;

  logic      queued_restarts[$];
  tent_out_t expected_outputs[$];

  logic steady = 1'b0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   faults_seen = 0;
  int   items_sent = 0;
  int   settings_run = 0;
  int   cycle_count = 0;

  rescaled_tent_map_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // one orbit step: optional reload, emit sample, advance the state
  function automatic tent_out_t tent_step(input logic restart);
    logic [63:0]  x, t, p, q, r, d, quo, rem;
    logic [127:0] prod, lhs, rhs;
    logic         sat;
    int           i;
    tent_out_t    res;
    if (restart) orbit_x = (seed_reg > UNIT) ? 33'(UNIT) : seed_reg;
    res.sample = (orbit_x >= UNIT) ? 32'hFFFF_FFFF : orbit_x[31:0];
    res.fault = 1'b0;
    x = (orbit_x > UNIT) ? UNIT : 64'(orbit_x);
    t = (x < HALF) ? x : UNIT - x;
    prod = 128'(slope_reg) * 128'(t);
    p = prod[91:28];
    if (slope_reg <= SLOPE_TWO) begin
      orbit_x = (p > UNIT) ? 33'(UNIT) : 33'(p);
    end else begin
      // fold modulo one, then rescale inside the band around one half
      q = p & (UNIT - 64'd1);
      r = 64'(slope_reg) & FOLD_MASK;
      d = (x >= HALF) ? x - HALF : HALF - x;
      lhs = 128'(slope_reg) * 128'(d << 1);
      rhs = 128'(r) * 128'(UNIT);
      if (lhs > rhs) begin
        orbit_x = 33'(q);
      end else if (r == 64'd0) begin
        orbit_x = '0;
        res.fault = 1'b1;
      end else begin
        quo = q / r;
        rem = q % r;
        sat = (quo > UNIT);
        for (i = 0; i < QUO_STEPS; i++) begin
          if (!sat) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= r) begin
              rem = rem - r;
              quo[0] = 1'b1;
            end
            if (quo > UNIT) sat = 1'b1;
          end
        end
        orbit_x = sat ? 33'(UNIT) : 33'(quo);
      end
    end
    return res;
  endfunction

  // input driver: feeds queued restart flags, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'd0;
    end else if (!in_tvalid || in_tready) begin
      if (queued_restarts.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
        in_tvalid <= 1'b1;
        in_tdata <= {7'd0, queued_restarts.pop_front()};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: register writes, prediction on input, check on output
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      seed_reg = rtm_pkg::SEED_RESET[32:0];
      slope_reg = rtm_pkg::SLOPE_RESET;
      orbit_x = rtm_pkg::SEED_RESET[32:0];
      expected_outputs.delete();
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 14);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3])
          rtm_pkg::REG_SEED:  seed_reg = cfg_pwdata[32:0];
          rtm_pkg::REG_SLOPE: slope_reg = cfg_pwdata[31:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_outputs.push_back(tent_step(in_tdata[0]));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_outputs.size() == 0) begin
          $error("unexpected result transaction: sample %h fault %b", out_tdata, out_tuser);
          mismatches++;
        end else begin
          tent_out_t want;
          want = expected_outputs.pop_front();
          if (want.fault) faults_seen++;
          if (out_tdata !== want.sample) begin
            $error("sample: expected %h, actual %h", want.sample, out_tdata);
            mismatches++;
          end
          if (out_tuser !== want.fault) begin
            $error("fault: expected %b, actual %b", want.fault, out_tuser);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("rescaled_tent_map_generator_top verification failed");
      $finish;
    end
  end

  // wait until the block has nothing in flight, checked between edges
  task automatic drain_results();
    @(negedge clk);
    while (queued_restarts.size() != 0 || in_tvalid || expected_outputs.size() != 0)
      @(negedge clk);
  endtask

  // two-phase register write
  task automatic write_reg(input logic idx, input logic [63:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // new register setting, then a run starting with a restart
  task automatic run_phase(input logic [32:0] seed_val, input logic [31:0] slope_val,
                           input int n_items, input int restart_pct);
    int k;
    drain_results();
    write_reg(rtm_pkg::REG_SEED, {($urandom_range(1) ? 31'($urandom) : 31'd0), seed_val});
    write_reg(rtm_pkg::REG_SLOPE, {($urandom_range(1) ? 32'($urandom) : 32'd0), slope_val});
    settings_run++;
    queued_restarts.push_back(1'b1);
    for (k = 1; k < n_items; k++) queued_restarts.push_back($urandom_range(99) < restart_pct);
    items_sent += n_items;
  endtask

  initial begin
    int          n;
    int          phase_idx;
    int          random_items;
    logic [32:0] seed_val;
    logic [31:0] slope_val;
    phase_idx = 0;
    random_items = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // orbit from reset defaults, then a reload
    queued_restarts.push_back(1'b0);
    queued_restarts.push_back(1'b1);
    queued_restarts.push_back(1'b0);
    items_sent += 3;
    // zero state with the steepest slope
    run_phase(33'd0, 32'hFFFF_FFFF, 2, 0);
    // state exactly one saturates the sample, slope exactly two
    run_phase(33'(UNIT), SLOPE_TWO, 2, 0);
    // seed above one is clamped, flat slope
    run_phase(33'h1_FFFF_FFFF, 32'd0, 2, 0);
    // even integer slope at one half divides by zero
    run_phase(33'(HALF), 32'h4000_0000, 3, 0);
    // one half with slope three lands in the band
    run_phase(33'(HALF), 32'h3000_0000, 2, 0);
    // just above two, smallest seed
    run_phase(33'd1, SLOPE_TWO + 32'd1, 3, 0);
    run_phase({1'b0, 32'($urandom)}, SLOPE_TWO - 32'd1, 2, 0);
    run_phase({1'b0, 32'($urandom)}, 32'($urandom_range(32'hFFFF_FFFF, 32'h2000_0001)), 4, 50);

    // random settings and orbits
    while (random_items < RAND_ITEMS) begin
      case ($urandom_range(9))
        0:       seed_val = 33'(HALF);
        1:       seed_val = {1'b1, 32'($urandom)};
        2:       seed_val = 33'(UNIT);
        3:       seed_val = 33'($urandom_range(15));
        default: seed_val = {1'b0, 32'($urandom)};
      endcase
      case ($urandom_range(9))
        0, 1, 2:    slope_val = 32'($urandom_range(SLOPE_TWO));
        3, 4, 5, 6: slope_val = 32'($urandom_range(32'hFFFF_FFFF, 32'h2000_0001));
        7:          slope_val = 32'($urandom_range(7, 2)) << 29;
        8:          slope_val = SLOPE_TWO + 32'($urandom_range(4)) - 32'd2;
        default: begin
          case ($urandom_range(3))
            0:       slope_val = 32'd0;
            1:       slope_val = 32'hFFFF_FFFF;
            2:       slope_val = SLOPE_TWO;
            default: slope_val = SLOPE_TWO + 32'd1;
          endcase
        end
      endcase
      steady = (phase_idx >= 8 && phase_idx < 14);
      n = $urandom_range(60, 15);
      run_phase(seed_val, slope_val, n, 4);
      random_items += n;
      phase_idx++;
    end

    drain_results();
    steady = 1'b0;
    repeat (LATENCY) @(posedge clk);
    if (expected_outputs.size() != 0) begin
      $error("%0d expected results never arrived", expected_outputs.size());
      mismatches++;
    end
    $display("sent %0d requests over %0d register settings", items_sent, settings_run);
    $display("checked %0d results, %0d of them divide-by-zero faults", results_seen,
             faults_seen);
    if (mismatches == 0) begin
      $display("rescaled_tent_map_generator_top verification clean");
    end else begin
      $display("rescaled_tent_map_generator_top verification failed");
    end
    $finish;
  end

endmodule
